// ----- rtl/irpd_pkg.sv -----
package irpd_pkg;

	// Frame phases of the transmitter.
	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_LEAD_MARK  = 3'd1,
		PH_LEAD_SPACE = 3'd2,
		PH_BIT_MARK   = 3'd3,
		PH_BIT_SPACE  = 3'd4,
		PH_TRAIL_MARK = 3'd5
	} phase_t;

	// Input opcodes.
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_FIRST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_SECOND  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_MARK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_SPACE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd6;

	// Register values after reset.
	localparam logic [7:0] RST_ADDR_FIRST  = 8'd255;
	localparam logic [7:0] RST_ADDR_SECOND = 8'd255;
	localparam logic [7:0] RST_LEAD_MARK   = 8'd223;
	localparam logic [7:0] RST_LEAD_SPACE  = 8'd117;
	localparam logic [7:0] RST_BIT_MARK    = 8'd10;
	localparam logic [7:0] RST_ONE_SPACE   = 8'd15;
	localparam logic [7:0] RST_ZERO_SPACE  = 8'd41;

	// Number of data bits in a frame, and the index of the last one.
	localparam int FRAME_BITS = 32;
	localparam logic [4:0] LAST_BIT = 5'd31;

endpackage

// ----- rtl/ir_pulse_distance_transmitter_top.sv -----
// Pulse-distance infrared frame transmitter. Each input word is either one
// carrier-period tick (opcode 0) or a request to start a frame (opcode 1)
// carrying a command byte; a start while a frame is running is ignored.
// A frame is a leader mark, a leader space, 32 data bits sent LSB first
// (first address, second address, inverted command, command), each a mark
// and then a short space for a one or a long space for a zero, and finally
// a trailer mark. Phase lengths in ticks come from the configuration
// registers, and a new value takes effect immediately; a length of zero acts
// as one. Every input word gives exactly one output word describing the
// state after that word: mark, busy_res, and frame_done on the tick that
// ends the trailer. The block takes one word per clock cycle: the frame
// state updates in the cycle of acceptance and the result sits in an output
// register, so input is stalled only while that register holds a word that
// the receiver is stalling.
module ir_pulse_distance_transmitter_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               opcode,
	input  logic [7:0]                         command,
	// Output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               mark,
	output logic                               busy_res,
	output logic                               frame_done,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [irpd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [irpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import irpd_pkg::*;

	logic [7:0] addr_first_q;
	logic [7:0] addr_second_q;
	logic [7:0] lead_mark_q;
	logic [7:0] lead_space_q;
	logic [7:0] bit_mark_q;
	logic [7:0] one_space_q;
	logic [7:0] zero_space_q;

	phase_t                  phase_q, phase_d;
	logic [7:0]              tick_q, tick_d;
	logic [4:0]              bit_idx_q, bit_idx_d;
	logic [FRAME_BITS-1:0]   shift_q, shift_d;
	logic                    done_d;

	logic       out_valid_q;
	logic       mark_q, busy_q, done_q;
	logic       mark_d, busy_d;
	logic       in_accept;
	logic [7:0] phase_len;
	logic [8:0] tick_inc;

	// Handshake: accept while the output register is free or being emptied.
	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_first_q  <= RST_ADDR_FIRST;
			addr_second_q <= RST_ADDR_SECOND;
			lead_mark_q   <= RST_LEAD_MARK;
			lead_space_q  <= RST_LEAD_SPACE;
			bit_mark_q    <= RST_BIT_MARK;
			one_space_q   <= RST_ONE_SPACE;
			zero_space_q  <= RST_ZERO_SPACE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ADDR_FIRST:  addr_first_q  <= cfg_data;
				REG_ADDR_SECOND: addr_second_q <= cfg_data;
				REG_LEAD_MARK:   lead_mark_q   <= cfg_data;
				REG_LEAD_SPACE:  lead_space_q  <= cfg_data;
				REG_BIT_MARK:    bit_mark_q    <= cfg_data;
				REG_ONE_SPACE:   one_space_q   <= cfg_data;
				REG_ZERO_SPACE:  zero_space_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Length of the current phase in ticks.
	always_comb begin
		unique case (phase_q)
			PH_LEAD_MARK:  phase_len = lead_mark_q;
			PH_LEAD_SPACE: phase_len = lead_space_q;
			PH_BIT_SPACE:  phase_len = shift_q[0] ? one_space_q : zero_space_q;
			default:       phase_len = bit_mark_q;
		endcase
	end

	assign tick_inc = {1'b0, tick_q} + 9'd1;

	// Next frame state for the accepted word.
	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		done_d    = 1'b0;
		if (opcode == OP_START) begin
			if (phase_q == PH_IDLE) begin
				shift_d   = {command, ~command, addr_second_q, addr_first_q};
				phase_d   = PH_LEAD_MARK;
				tick_d    = '0;
				bit_idx_d = '0;
			end
		end else if (phase_q != PH_IDLE) begin
			if (tick_inc >= {1'b0, phase_len}) begin
				tick_d = '0;
				unique case (phase_q)
					PH_LEAD_MARK:  phase_d = PH_LEAD_SPACE;
					PH_LEAD_SPACE: phase_d = PH_BIT_MARK;
					PH_BIT_MARK:   phase_d = PH_BIT_SPACE;
					PH_BIT_SPACE: begin
						shift_d = {1'b0, shift_q[FRAME_BITS-1:1]};
						if (bit_idx_q >= LAST_BIT) begin
							bit_idx_d = '0;
							phase_d   = PH_TRAIL_MARK;
						end else begin
							bit_idx_d = bit_idx_q + 5'd1;
							phase_d   = PH_BIT_MARK;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end
				endcase
			end else begin
				tick_d = tick_inc[7:0];
			end
		end
	end

	// Result bits from the next state.
	always_comb begin
		busy_d = (phase_d != PH_IDLE);
		mark_d = (phase_d == PH_LEAD_MARK) || (phase_d == PH_BIT_MARK) ||
			(phase_d == PH_TRAIL_MARK);
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bit_idx_q <= '0;
			shift_q   <= '0;
		end else if (in_accept) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mark_q <= mark_d;
			busy_q <= busy_d;
			done_q <= done_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign mark       = mark_q;
	assign busy_res   = busy_q;
	assign frame_done = done_q;

`ifndef SYNTH
	// The word that ends a frame reports the transmitter as idle and dark.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> !busy_res && !mark)
		else $error("frame_done reported while still busy or marking");

	// While idle, the tick counter and bit index rest at zero.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> tick_q == '0 && bit_idx_q == '0)
		else $error("idle phase with stale counters");

	// A start accepted while idle always enters the leader mark.
	a_start_lead: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && opcode == OP_START && phase_q == PH_IDLE
		|=> phase_q == PH_LEAD_MARK && mark && busy_res)
		else $error("start did not begin the leader mark");

	// A held output word blocks the input side.
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input accepted while output word is held");
`endif

endmodule

// ----- bench/tb_ir_pulse_distance_transmitter_top.sv -----
module tb_ir_pulse_distance_transmitter_top;

	import irpd_pkg::*;

	// One input word and the three levels that each word produces.
	typedef struct packed {
		logic       op;
		logic [7:0] cmd;
	} ir_word_t;

	typedef struct packed {
		logic mark;
		logic busy;
		logic done;
	} ir_levels_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_TICK;
	logic [7:0] command = 8'd0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic mark;
	logic busy_res;
	logic frame_done;

	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ADDR_FIRST;
	logic [CFG_DATA_W-1:0] cfg_data = 8'd0;

	ir_pulse_distance_transmitter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.command(command),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mark(mark),
		.busy_res(busy_res),
		.frame_done(frame_done),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Words waiting to be driven and levels waiting to come out.
	ir_word_t pending_words[$];
	ir_levels_t expected_levels[$];

	// Shadow of the transmitter: register copy and frame state.
	logic [7:0] tx_cfg [0:6];
	phase_t tx_phase = PH_IDLE;
	logic [7:0] tx_ticks = 8'd0;
	logic [4:0] tx_bit = 5'd0;
	logic [31:0] tx_shift = 32'd0;

	int words_queued = 0;
	int words_taken = 0;
	int taken_seen = 0;
	int levels_checked = 0;
	int frames_seen = 0;
	int settings_done = 0;
	int error_count = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit quiet = 1'b0;

	// Length in ticks of the current phase; a zero register acts as one tick.
	function automatic logic [7:0] phase_ticks();
		case (tx_phase)
			PH_LEAD_MARK: return tx_cfg[REG_LEAD_MARK];
			PH_LEAD_SPACE: return tx_cfg[REG_LEAD_SPACE];
			PH_BIT_MARK: return tx_cfg[REG_BIT_MARK];
			PH_BIT_SPACE: return tx_shift[0] ? tx_cfg[REG_ONE_SPACE] : tx_cfg[REG_ZERO_SPACE];
			default: return tx_cfg[REG_BIT_MARK];
		endcase
	endfunction

	// Advance the shadow frame by one word and give the levels after it.
	task automatic ir_frame_step(input logic op, input logic [7:0] cmd, output ir_levels_t lv);
		logic [8:0] cnt;
		logic done;
		done = 1'b0;
		if (op == OP_START) begin
			if (tx_phase == PH_IDLE) begin
				tx_shift = {cmd, ~cmd, tx_cfg[REG_ADDR_SECOND], tx_cfg[REG_ADDR_FIRST]};
				tx_phase = PH_LEAD_MARK;
				tx_ticks = 8'd0;
				tx_bit = 5'd0;
			end
		end else if (tx_phase != PH_IDLE) begin
			cnt = {1'b0, tx_ticks} + 9'd1;
			if (cnt >= {1'b0, phase_ticks()}) begin
				tx_ticks = 8'd0;
				case (tx_phase)
					PH_LEAD_MARK: tx_phase = PH_LEAD_SPACE;
					PH_LEAD_SPACE: tx_phase = PH_BIT_MARK;
					PH_BIT_MARK: tx_phase = PH_BIT_SPACE;
					PH_BIT_SPACE: begin
						tx_shift = tx_shift >> 1;
						if (tx_bit >= LAST_BIT) begin
							tx_bit = 5'd0;
							tx_phase = PH_TRAIL_MARK;
						end else begin
							tx_bit = tx_bit + 5'd1;
							tx_phase = PH_BIT_MARK;
						end
					end
					default: begin
						tx_phase = PH_IDLE;
						done = 1'b1;
					end
				endcase
			end else begin
				tx_ticks = cnt[7:0];
			end
		end
		lv.mark = (tx_phase == PH_LEAD_MARK) || (tx_phase == PH_BIT_MARK) ||
			(tx_phase == PH_TRAIL_MARK);
		lv.busy = (tx_phase != PH_IDLE);
		lv.done = done;
	endtask

	function automatic int dur(input logic [7:0] v);
		return (v == 8'd0) ? 1 : int'(v);
	endfunction

	// Ticks a whole frame with this command takes under the current registers.
	function automatic int frame_tick_budget(input logic [7:0] cmd);
		logic [31:0] bits;
		int t;
		int k;
		bits = {cmd, ~cmd, tx_cfg[REG_ADDR_SECOND], tx_cfg[REG_ADDR_FIRST]};
		t = dur(tx_cfg[REG_LEAD_MARK]) + dur(tx_cfg[REG_LEAD_SPACE]) +
			dur(tx_cfg[REG_BIT_MARK]);
		for (k = 0; k < FRAME_BITS; k++) begin
			t += dur(tx_cfg[REG_BIT_MARK]) +
				(bits[k] ? dur(tx_cfg[REG_ONE_SPACE]) : dur(tx_cfg[REG_ZERO_SPACE]));
		end
		return t;
	endfunction

	// Mostly back to back, sometimes a short gap, rarely a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic queue_word(input logic op, input logic [7:0] cmd);
		ir_word_t w;
		w.op = op;
		w.cmd = cmd;
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic queue_ticks(input int n);
		int i;
		for (i = 0; i < n; i++)
			queue_word(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	// A start and the ticks that carry the frame to its end; a broken frame
	// stops early, and now and then a start lands in the middle of a frame.
	task automatic queue_frame(input logic [7:0] cmd, input bit broken);
		int n;
		int i;
		n = frame_tick_budget(cmd);
		if (broken)
			n = $urandom_range(0, n - 1);
		queue_word(OP_START, cmd);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 2)
				queue_word(OP_START, 8'($urandom_range(0, 255)));
			queue_word(OP_TICK, 8'($urandom_range(0, 255)));
		end
		if (!broken)
			queue_ticks($urandom_range(0, 3));
	endtask

	// Register writes happen only with no word in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		tx_cfg[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(input logic [7:0] a1, input logic [7:0] a2, input logic [7:0] lm,
		input logic [7:0] ls, input logic [7:0] bm, input logic [7:0] one,
		input logic [7:0] zero);
		write_reg(REG_ADDR_FIRST, a1);
		write_reg(REG_ADDR_SECOND, a2);
		write_reg(REG_LEAD_MARK, lm);
		write_reg(REG_LEAD_SPACE, ls);
		write_reg(REG_BIT_MARK, bm);
		write_reg(REG_ONE_SPACE, one);
		write_reg(REG_ZERO_SPACE, zero);
		settings_done++;
	endtask

	// Wait until every queued word has been taken and answered.
	task automatic drain();
		while (pending_words.size() != 0 || expected_levels.size() != 0 || in_valid)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	function automatic logic [7:0] small_ticks();
		return 8'($urandom_range(1, ($urandom_range(0, 2) == 0) ? 6 : 2));
	endfunction

	// Input driver: presents the next pending word once the current one is taken.
	always @(negedge clk) begin : drive_words
		ir_word_t w;
		if (arst_n && (!in_valid || words_taken != taken_seen)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left = gap_left - 1;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				opcode <= w.op;
				command <= w.cmd;
				gap_left = quiet ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
		taken_seen = words_taken;
	end

	// Receiver back-pressure with the same mix of short and long stalls.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (arst_n && !quiet)
				stall_left = pick_gap();
		end
	end

	// Each accepted word steps the shadow frame and queues its levels.
	always @(posedge clk) begin : take_words
		ir_levels_t lv;
		if (arst_n && in_valid && !in_stall) begin
			ir_frame_step(opcode, command, lv);
			expected_levels.push_back(lv);
			words_taken++;
		end
	end

	// Each accepted output word is compared with the oldest expected levels.
	always @(posedge clk) begin : check_levels
		ir_levels_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_levels.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected output word: mark=%0b busy=%0b done=%0b",
						mark, busy_res, frame_done);
			end else begin
				want = expected_levels.pop_front();
				if (mark !== want.mark || busy_res !== want.busy ||
						frame_done !== want.done) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch at word %0d: mark/busy/done %0b%0b%0b, got %0b%0b%0b",
							levels_checked, want.mark, want.busy, want.done,
							mark, busy_res, frame_done);
				end
				levels_checked++;
			end
			if (frame_done === 1'b1)
				frames_seen++;
		end
	end

	initial begin
		int kind;
		int nframes;
		int f;
		logic [7:0] lm, ls, bm, one, zero;
		tx_cfg[REG_ADDR_FIRST] = RST_ADDR_FIRST;
		tx_cfg[REG_ADDR_SECOND] = RST_ADDR_SECOND;
		tx_cfg[REG_LEAD_MARK] = RST_LEAD_MARK;
		tx_cfg[REG_LEAD_SPACE] = RST_LEAD_SPACE;
		tx_cfg[REG_BIT_MARK] = RST_BIT_MARK;
		tx_cfg[REG_ONE_SPACE] = RST_ONE_SPACE;
		tx_cfg[REG_ZERO_SPACE] = RST_ZERO_SPACE;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Reset timings: a tick while idle, a start, a start while busy.
		queue_word(OP_TICK, 8'hFF);
		queue_word(OP_START, 8'h00);
		queue_word(OP_START, 8'hFF);
		queue_word(OP_TICK, 8'hAA);
		queue_word(OP_TICK, 8'h55);
		queue_word(OP_TICK, 8'h00);
		drain();

		// Shorten every phase in the middle of the frame; the latched
		// addresses must survive the new address registers.
		set_all(8'h00, 8'h00, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
		queue_ticks(frame_tick_budget(8'h00) + 2);
		drain();

		// Zero lengths act as one tick; a start right after the frame ends.
		set_all(8'hFF, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		queue_frame(8'h5A, 1'b0);
		queue_frame(8'hA5, 1'b0);
		drain();

		// Longest phases, then cut short in the middle of the leader space.
		set_all(8'hFF, 8'h00, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		queue_word(OP_START, 8'hC3);
		queue_ticks(300);
		drain();
		set_all(8'h00, 8'hFF, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
		queue_ticks(frame_tick_budget(8'hC3) + 2);
		drain();

		// Longest bit phases, then cut short after the first bit.
		set_all(8'h81, 8'h7E, 8'd1, 8'd1, 8'd255, 8'd255, 8'd255);
		queue_word(OP_START, 8'h3C);
		queue_ticks(600);
		drain();
		set_all(8'h81, 8'h7E, 8'd2, 8'd1, 8'd3, 8'd1, 8'd2);
		queue_ticks(frame_tick_budget(8'h3C) + 2);
		drain();

		// Random rounds: a fresh setting, then one or two frames, some broken.
		while (words_queued < 1850) begin
			kind = $urandom_range(0, 9);
			quiet = ($urandom_range(0, 3) == 0);
			if (kind == 0) begin
				lm = 8'd1;
				ls = 8'd1;
				bm = 8'd1;
				one = 8'd1;
				zero = 8'd1;
			end else begin
				lm = small_ticks();
				ls = small_ticks();
				bm = small_ticks();
				one = small_ticks();
				zero = small_ticks();
			end
			set_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				lm, ls, bm, one, zero);
			nframes = $urandom_range(1, 2);
			for (f = 0; f < nframes; f++)
				queue_frame(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 15);
			drain();
		end
		quiet = 1'b0;

		drain();
		repeat (4) @(negedge clk);
		$display("tb: %0d words driven over %0d register settings, %0d output words checked",
			words_taken, settings_done, levels_checked);
		$display("tb: %0d frames completed, %0d errors, %0d words unanswered",
			frames_seen, error_count, expected_levels.size());
		if (error_count == 0 && expected_levels.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Hard limit on the run.
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
